/* hw/rtl/crbc_pkg.sv */
// Shared types, constants and the divider step for the coordinate rank bucket code block.
`default_nettype none
package crbc_pkg;
    localparam int DIMENSIONS   = 6;
    localparam int BUCKETS      = 4;
    localparam int LOG2_BUCKETS = 2;
    localparam int COORD_W      = 16;
    localparam int DIV_W        = 17;
    localparam int DVR_W        = 16;
    localparam int DESC_W       = 33;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 33;
    localparam int CODE_W       = 8;
    localparam int SUM_W        = 20;
    localparam int RANK_W       = 4;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = 2;
    localparam int Q_CNT_W      = 3;
    localparam int NSTAGE       = 2 * DIV_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DESC_0   = 3'd2;
    localparam logic [DESC_W-1:0]    DESC_RESET   = 33'h1_0001_0001;

    typedef struct packed {
        logic signed [COORD_W-1:0]             base_x;
        logic signed [COORD_W-1:0]             base_y;
        logic [DIMENSIONS-1:0][DESC_W-1:0]     desc;
    } t_cfg;

    typedef struct packed {
        logic [DIMENSIONS-1:0][DIV_W-1:0] mag;
        logic [DIMENSIONS-1:0]            neg;
    } t_item;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] a;
    } t_div;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic t_div div_step(t_div s, logic [DVR_W-1:0] d);
        logic [DIV_W-1:0] sh;
        logic             ge;
        t_div             o;
        sh    = {s.rem[DIV_W-2:0], s.a[DIV_W-1]};
        ge    = (sh >= DIV_W'(d));
        o.rem = ge ? (sh - DIV_W'(d)) : sh;
        o.a   = {s.a[DIV_W-2:0], ge};
        return o;
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/coordinate_rank_bucket_code.sv */
// Throughput: one point per cycle unless held; a 17-stage remainder pipeline
// followed by a 17-stage quotient pipeline, then one sum stage and one ranking stage.
// The whole back pipeline holds while its last result cannot enter the result queue.
// Reset (synchronous, active low) empties both queues and restores the register defaults.
`default_nettype none
module coordinate_rank_bucket_code (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [15:0]                  i_point_x,
    input  wire logic signed [15:0]                  i_point_y,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [7:0]                               o_rank_code,
    input  wire logic                                i_cfg_we,
    input  wire logic [crbc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [crbc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import crbc_pkg::*;

    t_cfg   r_cfg;
    t_item  f_item, q_item;
    logic   q_empty, q_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_x <= '0;
            r_cfg.base_y <= '0;
            for (int d = 0; d < DIMENSIONS; d++) r_cfg.desc[d] <= DESC_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ORIGIN_X) r_cfg.base_x <= i_cfg_data[15:0];
            else if (i_cfg_idx == CFG_ORIGIN_Y) r_cfg.base_y <= i_cfg_data[15:0];
            else begin
                for (int d = 0; d < DIMENSIONS; d++) begin
                    if (i_cfg_idx == CFG_DESC_0 + CFG_IDX_W'(d))
                        r_cfg.desc[d] <= i_cfg_data[DESC_W-1:0];
                end
            end
        end
    end

    crbc_front u_front (
        .i_cfg     (r_cfg),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .o_item    (f_item)
    );

    crbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (f_item),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  (q_item)
    );

    crbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_q_data    (q_item),
        .o_q_rd      (q_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_rank_code (o_rank_code)
    );

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> !q_empty)
        else $error("accepted point missing from front queue");

    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(full && q_empty))
        else $error("front queue both full and empty");

    a_no_read_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_empty |-> !q_rd)
        else $error("back end read an empty queue");
endmodule
`default_nettype wire

/* hw/rtl/crbc_front.sv */
// Front end: subtract the origin, pick the axis operand of each dimension and split it into sign and magnitude.
`default_nettype none
module crbc_front (
    input  wire  crbc_pkg::t_cfg            i_cfg,
    input  wire logic signed [15:0]         i_point_x,
    input  wire logic signed [15:0]         i_point_y,
    output crbc_pkg::t_item                 o_item
);
    import crbc_pkg::*;

    logic signed [DIV_W-1:0] xr;
    logic signed [DIV_W-1:0] yr;
    logic signed [DIV_W-1:0] sel;

    assign xr = DIV_W'(i_point_x) - DIV_W'(i_cfg.base_x);
    assign yr = DIV_W'(i_point_y) - DIV_W'(i_cfg.base_y);

    always_comb begin
        for (int d = 0; d < DIMENSIONS; d++) begin
            sel = i_cfg.desc[d][DESC_W-1] ? xr : yr;
            o_item.neg[d] = sel[DIV_W-1];
            o_item.mag[d] = sel[DIV_W-1] ? DIV_W'(-sel) : DIV_W'(sel);
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/crbc_queue.sv */
// Short queue between the front end and the divide pipeline.
`default_nettype none
module crbc_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  wire crbc_pkg::t_item i_data,
    output logic                 o_full,
    input  wire logic            i_rd,
    output logic                 o_empty,
    output crbc_pkg::t_item      o_data
);
    import crbc_pkg::*;

    t_item                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wp, r_rp;
    logic [Q_CNT_W-1:0]   r_cnt, n_cnt;
    logic                 wr, rd;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_wr && !o_full;
    assign rd      = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (wr && !rd) n_cnt = r_cnt + 1'b1;
        else if (rd && !wr) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/crbc_back.sv */
// Back end: pipelined remainder and quotient, bucket sums, ranking and result queue.
`default_nettype none
module crbc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire crbc_pkg::t_cfg  i_cfg,
    input  wire logic            i_q_empty,
    input  wire crbc_pkg::t_item i_q_data,
    output logic                 o_q_rd,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output logic [7:0]           o_rank_code
);
    import crbc_pkg::*;

    t_div                   r_div [NSTAGE][DIMENSIONS];
    t_div                   n_div [NSTAGE][DIMENSIONS];
    logic [DIMENSIONS-1:0]  r_neg [NSTAGE];
    logic [NSTAGE-1:0]      r_vld;
    logic signed [SUM_W-1:0] r_sum [BUCKETS];
    logic signed [SUM_W-1:0] n_sum [BUCKETS];
    logic                   r_svld;
    logic [CODE_W-1:0]      r_code, n_code;
    logic                   r_cvld;
    logic [CODE_W-1:0]      r_ob [2];
    logic                   r_owp, r_orp;
    logic [1:0]             r_ocnt, n_ocnt;
    logic                   adv, of_full, of_wr, of_rd;
    t_div                   seed;
    logic [RANK_W-1:0]      rank;
    logic signed [SUM_W-1:0] val;

    assign of_full = (r_ocnt == 2'd2);
    assign o_empty = (r_ocnt == 2'd0);
    // Whole pipeline advances together; hold only when a result cannot leave.
    assign adv     = !r_cvld || !of_full;
    assign o_q_rd  = adv && !i_q_empty;
    assign of_wr   = adv && r_cvld;
    assign of_rd   = i_pop && !o_empty;
    assign o_rank_code = r_ob[r_orp];

    always_comb begin
        for (int d = 0; d < DIMENSIONS; d++) begin
            for (int s = 0; s < NSTAGE; s++) begin
                if (s == 0) begin
                    seed.rem = '0;
                    seed.a   = i_q_data.mag[d];
                end else if (s == DIV_W) begin
                    seed.rem = '0;
                    seed.a   = r_div[s-1][d].rem;
                end else begin
                    seed = r_div[s-1][d];
                end
                // Modulus of zero leaves the remainder equal to the operand.
                n_div[s][d] = div_step(seed, (s < DIV_W) ? i_cfg.desc[d][31:16]
                                                        : i_cfg.desc[d][15:0]);
            end
        end
    end

    always_comb begin
        for (int b = 0; b < BUCKETS; b++) n_sum[b] = '0;
        for (int d = 0; d < DIMENSIONS; d++) begin
            val = SUM_W'(r_div[NSTAGE-1][d].a);
            if (r_neg[NSTAGE-1][d]) val = -val;
            if (i_cfg.desc[d][15:0] == '0) val = '0;
            n_sum[d % BUCKETS] = n_sum[d % BUCKETS] + val;
        end
    end

    always_comb begin
        n_code = '0;
        for (int b = 0; b < BUCKETS; b++) begin
            rank = '0;
            for (int o = 0; o < BUCKETS; o++) begin
                if (r_sum[o] > r_sum[b] || (r_sum[o] == r_sum[b] && o < b))
                    rank = rank + 1'b1;
            end
            n_code = (n_code << LOG2_BUCKETS)
                   | CODE_W'(rank & RANK_W'((1 << LOG2_BUCKETS) - 1));
        end
    end

    always_comb begin
        n_ocnt = r_ocnt;
        if (of_wr && !of_rd) n_ocnt = r_ocnt + 1'b1;
        else if (of_rd && !of_wr) n_ocnt = r_ocnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int s = 0; s < NSTAGE; s++) begin
                r_div[s] <= n_div[s];
                r_neg[s] <= (s == 0) ? i_q_data.neg : r_neg[s-1];
            end
            r_sum  <= n_sum;
            r_code <= n_code;
        end
        if (of_wr) r_ob[r_owp] <= r_code;
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_svld <= 1'b0;
            r_cvld <= 1'b0;
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (adv) begin
                r_vld  <= {r_vld[NSTAGE-2:0], !i_q_empty};
                r_svld <= r_vld[NSTAGE-1];
                r_cvld <= r_svld;
            end
            if (of_wr) r_owp <= !r_owp;
            if (of_rd) r_orp <= !r_orp;
            r_ocnt <= n_ocnt;
        end
    end
endmodule
`default_nettype wire
